/* hdl/dcm_pkg.sv */
package dcm_pkg;

    localparam int MAX_LEN  = 64;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 2;
    localparam int MARK_W   = 6;
    localparam int NUM_VALS = 1 << CHAR_W;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [MARK_W-1:0] t_mark;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [LEN_W-1:0]  t_len;

    localparam t_mark MARK_REPEATED = t_mark'(41);
    localparam t_mark MARK_SINGLE   = t_mark'(40);
    localparam t_cnt  COUNT_MAX     = t_cnt'(3);
    localparam t_char UPPER_FIRST   = t_char'(65);
    localparam t_char UPPER_LAST    = t_char'(90);
    localparam t_char CASE_OFFSET   = t_char'(32);

    typedef enum logic [2:0] {
        ST_CLR_ALL,
        ST_IDLE,
        ST_LOAD,
        ST_E_CHAR,
        ST_E_CNT,
        ST_E_OUT,
        ST_C_CHAR,
        ST_C_WR
    } t_state;

    function automatic t_char fold_lower(input t_char b);
        if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
            return t_char'(b + CASE_OFFSET);
        end
        return b;
    endfunction

endpackage

/* hdl/duplicate_character_marker.sv */
// Channel  Direction  Handshake                   Payload
// in       request    i_in_valid / o_in_stall     i_char_in, i_end_of_string
// out      result     o_out_valid / i_out_stall   o_mark, o_final_mark, o_overflowed
//
// Loading each byte takes one count memory read, then the count update.
// After the last byte, each stored byte is emitted by a character read, a count
// read and an output load, then a second pass reads each stored byte and clears its count.
// After reset a pass over every entry zeroes the count memory before the first request.
// A stalled output holds its register; emission waits until the register frees.
module duplicate_character_marker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dcm_pkg::t_char  i_char_in,
    input  logic            i_end_of_string,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dcm_pkg::t_mark  o_mark,
    output logic            o_final_mark,
    output logic            o_overflowed
);
    import dcm_pkg::*;

    t_char  r_char_mem [MAX_LEN];
    t_cnt   r_cnt_mem  [NUM_VALS];

    t_state r_state, n_state;
    t_len   r_len, n_len;
    t_len   r_k, n_k;
    logic   r_ovf, n_ovf;
    t_char  r_byte, n_byte;
    logic   r_last, n_last;
    logic   r_store, n_store;
    t_char  r_clr_idx, n_clr_idx;
    t_char  r_char_rd;
    t_cnt   r_cnt_rd;

    logic   r_out_valid, n_out_valid;
    t_mark  r_mark, n_mark;
    logic   r_final, n_final;
    logic   r_ovf_out, n_ovf_out;

    logic   in_accept;
    logic   out_free;
    logic   k_is_last;
    logic   char_we;
    logic   cnt_we;
    t_char  cnt_waddr;
    t_cnt   cnt_wdata;
    t_char  cnt_raddr;
    t_char  folded;

    assign folded    = fold_lower(i_char_in);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign k_is_last = (t_len'(r_k + t_len'(1)) == r_len);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR_ALL: begin
                if (r_clr_idx == t_char'(NUM_VALS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = r_last ? ST_E_CHAR : ST_IDLE;
            end
            ST_E_CHAR: n_state = ST_E_CNT;
            ST_E_CNT:  n_state = ST_E_OUT;
            ST_E_OUT: begin
                if (out_free) begin
                    n_state = k_is_last ? ST_C_CHAR : ST_E_CHAR;
                end
            end
            ST_C_CHAR: n_state = ST_C_WR;
            ST_C_WR: begin
                n_state = k_is_last ? ST_IDLE : ST_C_CHAR;
            end
            default:   n_state = ST_CLR_ALL;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        n_len       = r_len;
        n_k         = r_k;
        n_ovf       = r_ovf;
        n_byte      = r_byte;
        n_last      = r_last;
        n_store     = r_store;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_mark      = r_mark;
        n_final     = r_final;
        n_ovf_out   = r_ovf_out;
        char_we     = 1'b0;
        cnt_we      = 1'b0;
        cnt_waddr   = r_char_rd;
        cnt_wdata   = '0;
        cnt_raddr   = r_char_rd;
        case (r_state)
            ST_CLR_ALL: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr_idx;
                n_clr_idx = t_char'(r_clr_idx + t_char'(1));
            end
            ST_IDLE: begin
                cnt_raddr = folded;
                if (in_accept) begin
                    n_byte  = folded;
                    n_last  = i_end_of_string;
                    n_store = (r_len != t_len'(MAX_LEN));
                    if (r_len == t_len'(MAX_LEN)) begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                n_k = '0;
                if (r_store) begin
                    char_we   = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_waddr = r_byte;
                    cnt_wdata = (r_cnt_rd == COUNT_MAX) ? COUNT_MAX
                                                        : t_cnt'(r_cnt_rd + t_cnt'(1));
                    n_len     = t_len'(r_len + t_len'(1));
                end
            end
            ST_E_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_mark      = (r_cnt_rd > t_cnt'(1)) ? MARK_REPEATED : MARK_SINGLE;
                    n_final     = k_is_last;
                    n_ovf_out   = r_ovf;
                    n_k         = k_is_last ? '0 : t_len'(r_k + t_len'(1));
                end
            end
            ST_C_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_char_rd;
                if (k_is_last) begin
                    n_k   = '0;
                    n_len = '0;
                    n_ovf = 1'b0;
                end else begin
                    n_k = t_len'(r_k + t_len'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (char_we) begin
            r_char_mem[r_len[IDX_W-1:0]] <= r_byte;
        end
        r_char_rd <= r_char_mem[r_k[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= r_cnt_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR_ALL;
            r_len       <= '0;
            r_k         <= '0;
            r_ovf       <= 1'b0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_k         <= n_k;
            r_ovf       <= n_ovf;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_last    <= n_last;
        r_store   <= n_store;
        r_mark    <= n_mark;
        r_final   <= n_final;
        r_ovf_out <= n_ovf_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_mark       = r_mark;
    assign o_final_mark = r_final;
    assign o_overflowed = r_ovf_out;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= t_len'(MAX_LEN))
        else $error("stored length beyond buffer");

    a_drop_sets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_len == t_len'(MAX_LEN)) |=> r_ovf)
        else $error("dropped byte did not set overflow");

    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_OUT && out_free) |=> o_out_valid)
        else $error("emission did not load output register");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C_WR && k_is_last) |=> (r_len == '0 && !r_ovf))
        else $error("string state not cleared after emission");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcm_pkg::*;

    typedef struct packed {
        t_mark mark;
        logic  final_mark;
        logic  overflowed;
    } t_mark_rec;

    class mark_scoreboard;
        t_char       folded_store[MAX_LEN];
        t_cnt        char_count[NUM_VALS];
        int unsigned held_len;
        bit          dropped;
        t_mark_rec   pending_marks[$];
        int unsigned mismatches;
        int unsigned marks_checked;

        function new();
            foreach (char_count[i]) char_count[i] = '0;
            held_len      = 0;
            dropped       = 1'b0;
            mismatches    = 0;
            marks_checked = 0;
        endfunction

        // Fold, store and count one request; on the last byte queue the marks.
        function void note_request(t_char raw, logic last);
            t_char       b;
            t_mark_rec   rec;
            int unsigned k;
            b = raw;
            if (raw >= UPPER_FIRST && raw <= UPPER_LAST) begin
                b = raw + CASE_OFFSET;
            end
            if (held_len < MAX_LEN) begin
                folded_store[held_len] = b;
                held_len++;
                if (char_count[b] != COUNT_MAX) begin
                    char_count[b] = char_count[b] + 1'b1;
                end
            end else begin
                dropped = 1'b1;
            end
            if (!last) begin
                return;
            end
            for (k = 0; k < held_len; k++) begin
                rec.mark       = (char_count[folded_store[k]] > 1) ? MARK_REPEATED : MARK_SINGLE;
                rec.final_mark = (k + 1 == held_len);
                rec.overflowed = dropped;
                pending_marks.push_back(rec);
            end
            for (k = 0; k < held_len; k++) begin
                char_count[folded_store[k]] = '0;
            end
            held_len = 0;
            dropped  = 1'b0;
        endfunction

        function void check_mark(t_mark mark, logic fin, logic ovf);
            t_mark_rec exp_rec;
            marks_checked++;
            if (pending_marks.size() == 0) begin
                $error("unexpected result: mark=%0d final_mark=%0b overflowed=%0b",
                       mark, fin, ovf);
                mismatches++;
                return;
            end
            exp_rec = pending_marks.pop_front();
            if (mark !== exp_rec.mark) begin
                $error("mark: expected %0d, actual %0d", exp_rec.mark, mark);
                mismatches++;
            end
            if (fin !== exp_rec.final_mark) begin
                $error("final_mark: expected %0b, actual %0b", exp_rec.final_mark, fin);
                mismatches++;
            end
            if (ovf !== exp_rec.overflowed) begin
                $error("overflowed: expected %0b, actual %0b", exp_rec.overflowed, ovf);
                mismatches++;
            end
        endfunction
    endclass

    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  i_in_valid      = 1'b0;
    logic  o_in_stall;
    t_char i_char_in       = '0;
    logic  i_end_of_string = 1'b0;
    logic  o_out_valid;
    logic  i_out_stall     = 1'b0;
    t_mark o_mark;
    logic  o_final_mark;
    logic  o_overflowed;

    mark_scoreboard board = new();
    int unsigned    requests_sent = 0;
    int unsigned    stall_left    = 0;
    int unsigned    rx_cycle      = 0;
    bit             pressure_done = 1'b0;

    duplicate_character_marker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mark          (o_mark),
        .o_final_mark    (o_final_mark),
        .o_overflowed    (o_overflowed)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_char pick_char();
        int unsigned r;
        t_char c;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            c = t_char'(8'd97 + $urandom_range(0, 5));
            if ($urandom_range(0, 1)) begin
                c = c - CASE_OFFSET;
            end
            return c;
        end
        return t_char'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input t_char c, input logic last, input bit calm);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_char_in       <= c;
        i_end_of_string <= last;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(c, last);
        requests_sent++;
    endtask

    task automatic send_word(input t_char word[$], input bit calm);
        foreach (word[i]) begin
            send_byte(word[i], i == word.size() - 1, calm);
        end
    endtask

    // Receiver: check accepted results, then pick the next stall.
    always @(posedge i_clk) begin : rx_side
        int unsigned g;
        rx_cycle <= rx_cycle + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_mark(o_mark, o_final_mark, o_overflowed);
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!pressure_done && board.marks_checked >= 20) begin
            pressure_done <= 1'b1;
            stall_left    <= 500;
            i_out_stall   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ((rx_cycle / 400) % 3 == 0) begin
            i_out_stall <= 1'b0;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                stall_left  <= g - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_char       word[$];
        int unsigned n_str;
        int unsigned len;
        int unsigned k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single letter, case pair, saturation, fold boundaries, high bytes, high-bit alias of A
        word = '{8'd65};
        send_word(word, 1'b0);
        word = '{8'd97, 8'd65};
        send_word(word, 1'b1);
        word = '{8'd97, 8'd65, 8'd97, 8'd65, 8'd98};
        send_word(word, 1'b0);
        word = '{8'd64, 8'd96, 8'd91, 8'd123, 8'd90, 8'd122};
        send_word(word, 1'b0);
        word = '{8'd0, 8'd255, 8'd128, 8'd200, 8'd232, 8'd0};
        send_word(word, 1'b1);
        word = '{8'd65, 8'd193, 8'd97};
        send_word(word, 1'b0);

        n_str = 0;
        while (requests_sent < 380) begin
            if (n_str == 0) begin
                len = MAX_LEN;
            end else if (n_str == 1) begin
                len = MAX_LEN + 1;
            end else if (n_str % 8 == 3) begin
                len = $urandom_range(MAX_LEN - 4, MAX_LEN + 8);
            end else if ($urandom_range(0, 99) < 70) begin
                len = $urandom_range(1, 8);
            end else begin
                len = $urandom_range(9, 20);
            end
            word.delete();
            for (k = 0; k < len; k++) begin
                word.push_back(pick_char());
            end
            send_word(word, n_str % 5 == 0);
            n_str++;
        end
        i_in_valid <= 1'b0;

        while (board.pending_marks.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
